// ===== src/hfa_pkg.sv =====
// hfa_pkg: shared types, codes and field widths of the hole fit allocator.
// No dependencies; every other file of the block but hfa_ram uses this package.
`default_nettype none

package hfa_pkg;

  // Fixed field widths of the request, response and register channels
  localparam int unsigned FUNC_W     = 1;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned AMOUNT_W   = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Default sizing of the hole table
  localparam int unsigned DEF_MAX_HOLES = 16;
  localparam int unsigned DEF_SIZE_BITS = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 1'b0,
    FUNC_REQUEST = 1'b1
  } func_e;

  // Code 3 is not a policy and falls back to first fit
  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_MODE   = 2'd0,
    CFG_HOLE_COUNT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  // Control handed to the fit compare unit with every hole examined
  typedef struct packed {
    fit_mode_e mode;
    logic      found;
  } fit_ctrl_t;

endpackage

`default_nettype wire

// ===== src/hfa_if.sv =====
// hfa_if: valid/ready channel interfaces of the hole fit allocator
// (request in, response out, register write). Depends on hfa_pkg.
`default_nettype none

interface hfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [hfa_pkg::FUNC_W-1:0]    func;
  logic [hfa_pkg::SLOT_W-1:0]    hole_slot;
  logic [hfa_pkg::AMOUNT_W-1:0]  amount;

  modport source (output valid, func, hole_slot, amount, input ready);
  modport sink   (input valid, func, hole_slot, amount, output ready);
endinterface

interface hfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [hfa_pkg::SLOT_W-1:0]    chosen_hole;
  logic [hfa_pkg::AMOUNT_W-1:0]  left_over;

  modport source (output valid, granted, chosen_hole, left_over, input ready);
  modport sink   (input valid, granted, chosen_hole, left_over, output ready);
endinterface

interface hfa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hfa_pkg::CFG_IDX_W-1:0]  reg_idx;
  logic [hfa_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

`default_nettype wire

// ===== src/hole_fit_allocator.sv =====
// hole_fit_allocator: top level; sequencer, register file and response stage.
// Depends on hfa_pkg, hfa_if, hfa_ram and hfa_fit_unit.
//
// A load request writes one hole size; loads can arrive back to back. An
// allocation request keeps the sequencer busy from acceptance until the next
// request can be taken: the table sits in a RAM with one read port, so the
// sequencer reads min(hole_count, MAX_HOLES) holes, one per cycle, through
// the shared fit compare unit, then judges the last hole read, then in its
// update step writes back the shrunk hole and loads the response register.
// With a count of zero it goes straight to the update step. The response
// register lets a new request enter while a response waits; only a finishing
// allocation holds in its update step until the response slot is free.
// Registers may be written only while no allocation is in flight.
`default_nettype none

module hole_fit_allocator #(
  parameter int unsigned MAX_HOLES = hfa_pkg::DEF_MAX_HOLES,
  parameter int unsigned SIZE_BITS = hfa_pkg::DEF_SIZE_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hfa_cfg_if.sink   cfg_i,
  hfa_req_if.sink   req_i,
  hfa_rsp_if.source rsp_o
);
  import hfa_pkg::*;

  localparam int unsigned IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_HOLES + 1);

  // Configuration registers
  logic [MODE_W-1:0]  mode_q;
  logic [COUNT_W-1:0] hcount_q;

  // Sequencer state
  state_e               state_q, state_d;
  logic [SIZE_BITS-1:0] amt_q, amt_d;
  logic [CNT_W-1:0]     limit_q, limit_d;
  logic [CNT_W-1:0]     rcnt_q, rcnt_d;
  logic                 ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]     ev_idx_q, ev_idx_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     pick_q, pick_d;
  logic [SIZE_BITS-1:0] best_q, best_d;

  // Response register
  logic                rsp_vld_q, rsp_vld_d;
  logic                rsp_grant_q, rsp_grant_d;
  logic [SLOT_W-1:0]   rsp_hole_q, rsp_hole_d;
  logic [AMOUNT_W-1:0] rsp_left_q, rsp_left_d;

  // RAM ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;

  logic                 take;
  fit_ctrl_t            fit_ctrl;
  logic                 req_acc;
  logic                 cfg_acc;
  logic [SIZE_BITS-1:0] amt_in;
  logic [SIZE_BITS-1:0] remain;
  logic [8:0]           slot_ext;
  logic [8:0]           lim_ext;
  logic [8:0]           max_ext;
  logic [31:0]          amt_wide;
  logic [31:0]          remain_wide;
  logic [8:0]           pick_wide;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      hcount_q <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_idx_e'(cfg_i.reg_idx))
        CFG_FIT_MODE:   mode_q   <= cfg_i.wdata[MODE_W-1:0];
        CFG_HOLE_COUNT: hcount_q <= cfg_i.wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // Bring amounts and indexes into table width
  assign amt_wide    = 32'(req_i.amount);
  assign amt_in      = amt_wide[SIZE_BITS-1:0];
  assign slot_ext    = 9'(req_i.hole_slot);
  assign max_ext     = 9'(MAX_HOLES);
  assign lim_ext     = (9'(hcount_q) > max_ext) ? max_ext : 9'(hcount_q);
  assign remain      = best_q - amt_q;
  assign remain_wide = 32'(remain);
  assign pick_wide   = 9'(pick_q);

  assign fit_ctrl.mode  = fit_mode_e'(mode_q);
  assign fit_ctrl.found = found_q;

  hfa_fit_unit #(
    .SIZE_BITS(SIZE_BITS)
  ) u_fit (
    .size_i  (ram_rdata),
    .amount_i(amt_q),
    .best_i  (best_q),
    .ctrl_i  (fit_ctrl),
    .take_o  (take)
  );

  always_comb begin
    state_d     = state_q;
    amt_d       = amt_q;
    limit_d     = limit_q;
    rcnt_d      = rcnt_q;
    ev_vld_d    = 1'b0;
    ev_idx_d    = ev_idx_q;
    found_d     = found_q;
    pick_d      = pick_q;
    best_d      = best_q;
    rsp_vld_d   = rsp_vld_q && !rsp_o.ready;
    rsp_grant_d = rsp_grant_q;
    rsp_hole_d  = rsp_hole_q;
    rsp_left_d  = rsp_left_q;
    ram_we      = 1'b0;
    ram_waddr   = slot_ext[IDX_W-1:0];
    ram_wdata   = amt_in;
    ram_raddr   = rcnt_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (func_e'(req_i.func) == FUNC_LOAD) begin
            // Drop loads aimed past the table
            ram_we = (slot_ext < max_ext);
          end else begin
            amt_d   = amt_in;
            limit_d = lim_ext[CNT_W-1:0];
            rcnt_d  = '0;
            found_d = 1'b0;
            state_d = (lim_ext == 9'd0) ? ST_UPDATE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue the next read while judging the hole read last cycle
        if (rcnt_q < limit_q) begin
          ev_vld_d = 1'b1;
          ev_idx_d = rcnt_q[IDX_W-1:0];
          rcnt_d   = rcnt_q + 1'b1;
        end
        if (ev_vld_q) begin
          if (take) begin
            found_d = 1'b1;
            pick_d  = ev_idx_q;
            best_d  = ram_rdata;
          end
          if (CNT_W'(ev_idx_q) == limit_q - 1'b1) begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        // Hold until the response slot is free
        if (!rsp_vld_q || rsp_o.ready) begin
          ram_we      = found_q;
          ram_waddr   = pick_q;
          ram_wdata   = remain;
          rsp_vld_d   = 1'b1;
          rsp_grant_d = found_q;
          rsp_hole_d  = found_q ? pick_wide[SLOT_W-1:0] : '0;
          rsp_left_d  = found_q ? remain_wide[AMOUNT_W-1:0] : '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ev_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      rcnt_q    <= '0;
      limit_q   <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ev_vld_q  <= ev_vld_d;
      found_q   <= found_d;
      rcnt_q    <= rcnt_d;
      limit_q   <= limit_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amt_q       <= amt_d;
    ev_idx_q    <= ev_idx_d;
    pick_q      <= pick_d;
    best_q      <= best_d;
    rsp_grant_q <= rsp_grant_d;
    rsp_hole_q  <= rsp_hole_d;
    rsp_left_q  <= rsp_left_d;
  end

  hfa_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(MAX_HOLES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.granted     = rsp_grant_q;
  assign rsp_o.chosen_hole = rsp_hole_q;
  assign rsp_o.left_over   = rsp_left_q;

`ifndef SYNTH
  a_req_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && func_e'(req_i.func) == FUNC_REQUEST) |=> (state_q != ST_IDLE))
    else $error("allocation request did not start the sequencer");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && ev_vld_q) |-> (CNT_W'(ev_idx_q) < limit_q))
    else $error("scan examined a hole past the active count");

  a_pick_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && found_q) |-> (best_q >= amt_q))
    else $error("chosen hole is smaller than the request");
`endif

endmodule

`default_nettype wire

// ===== src/hfa_ram.sv =====
// hfa_ram: generic single-write, single-read RAM with registered read data.
// No package dependencies; used for the hole size table.
`default_nettype none

module hfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/hfa_fit_unit.sv =====
// hfa_fit_unit: shared compare unit; decides whether the hole being examined
// replaces the current pick under the active policy. Depends on hfa_pkg.
`default_nettype none

module hfa_fit_unit #(
  parameter int unsigned SIZE_BITS = 16
) (
  input  wire logic [SIZE_BITS-1:0] size_i,
  input  wire logic [SIZE_BITS-1:0] amount_i,
  input  wire logic [SIZE_BITS-1:0] best_i,
  input  wire hfa_pkg::fit_ctrl_t   ctrl_i,
  output logic                      take_o
);
  import hfa_pkg::*;

  logic fits;
  logic better;

  assign fits = (size_i >= amount_i);

  // Ties keep the earlier pick, so only strict improvements win
  always_comb begin
    unique case (ctrl_i.mode)
      FIT_BEST:  better = (size_i < best_i);
      FIT_WORST: better = (size_i > best_i);
      default:   better = 1'b0;
    endcase
  end

  assign take_o = fits && (!ctrl_i.found || better);

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for hole_fit_allocator (first/best/worst fit table).
// Depends on hfa_pkg and the channel interfaces in hfa_if; predicts every grant
// from its own copy of the hole table and checks each response in order.
`default_nettype none

module tb_top;
  import hfa_pkg::*;

  localparam logic [MODE_W-1:0] FIT_UNUSED = 2'd3;
  localparam int unsigned       NUM_HOLES  = DEF_MAX_HOLES;
  localparam int unsigned       PHASES     = 10;
  localparam int unsigned       PHASE_OPS  = 175;
  localparam int unsigned       LONG_STALL = 400;
  localparam int unsigned       SETTLE     = 24;
  localparam int unsigned       MAX_PRINTS = 50;

  typedef struct {
    func_e               func;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amount;
  } hole_op_t;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   hole;
    logic [AMOUNT_W-1:0] left;
  } grant_t;

  logic clk_i;
  logic rst_ni;

  hfa_cfg_if cfg_bus ();
  hfa_req_if req_bus ();
  hfa_rsp_if rsp_bus ();

  hole_fit_allocator DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Shadow of the allocator state
  logic [AMOUNT_W-1:0] hole_size [NUM_HOLES];
  logic [MODE_W-1:0]   shadow_mode;
  logic [COUNT_W-1:0]  shadow_count;

  hole_op_t pending_ops[$];
  grant_t   grant_q[$];

  int unsigned fail_count;
  int unsigned ops_accepted;
  int unsigned grants_checked;
  int unsigned grants_won;

  // Sender and receiver pacing
  bit          req_taken;
  bit          src_gaps;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rsp_style;
  int unsigned rsp_run_left;
  int unsigned stall_left;
  bit          stall_req;
  bit          stall_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("tb: mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
  endtask

  // Apply one accepted request to the shadow table; queue the grant it causes
  function automatic void predict_grant(hole_op_t op);
    int unsigned span;
    int          pick;
    grant_t      res;
    if (op.func == FUNC_LOAD) begin
      if (op.slot < NUM_HOLES) hole_size[op.slot] = op.amount;
      return;
    end
    span = (shadow_count > NUM_HOLES) ? NUM_HOLES : shadow_count;
    pick = -1;
    for (int j = 0; j < span; j++) begin
      if (hole_size[j] >= op.amount) begin
        if (pick < 0) begin
          pick = j;
          if (shadow_mode != FIT_BEST && shadow_mode != FIT_WORST) break;
        end else if (shadow_mode == FIT_BEST && hole_size[j] < hole_size[pick]) begin
          pick = j;
        end else if (shadow_mode == FIT_WORST && hole_size[j] > hole_size[pick]) begin
          pick = j;
        end
      end
    end
    if (pick >= 0) begin
      hole_size[pick] = hole_size[pick] - op.amount;
      res.granted = 1'b1;
      res.hole    = SLOT_W'(pick);
      res.left    = hole_size[pick];
    end else begin
      res = '0;
    end
    grant_q.push_back(res);
  endfunction

  function automatic hole_op_t random_op();
    hole_op_t    op;
    int unsigned pick;
    op.slot = SLOT_W'($urandom_range(0, NUM_HOLES - 1));
    op.func = ($urandom_range(0, 99) < 35) ? FUNC_LOAD : FUNC_REQUEST;
    pick = $urandom_range(0, 9);
    if (op.func == FUNC_LOAD) begin
      op.amount = (pick == 0) ? '0 : (pick == 1) ? '1 : AMOUNT_W'($urandom);
    end else begin
      case (pick)
        0:       op.amount = '0;
        1:       op.amount = '1;
        2, 3:    op.amount = AMOUNT_W'($urandom_range(1, 255));
        4, 5, 6: op.amount = AMOUNT_W'($urandom_range(0, 16'h3fff));
        7:       op.amount = AMOUNT_W'($urandom);
        default: op.amount = AMOUNT_W'($urandom_range(0, 16'h0fff));
      endcase
    end
    return op;
  endfunction

  task automatic queue_op(func_e func, logic [SLOT_W-1:0] slot, logic [AMOUNT_W-1:0] amount);
    hole_op_t op;
    op.func   = func;
    op.slot   = slot;
    op.amount = amount;
    pending_ops.push_back(op);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.reg_idx <= idx;
    cfg_bus.wdata   <= data;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    if (idx == CFG_FIT_MODE) shadow_mode = data[MODE_W-1:0];
    else shadow_count = data[COUNT_W-1:0];
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Wait until every request is taken and every grant has come, then settle
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || req_bus.valid || grant_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Request driver: bursts of random length, separated by random gaps when src_gaps is set
  always @(negedge clk_i) begin
    hole_op_t op;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        req_bus.func      <= op.func;
        req_bus.hole_slot <= op.slot;
        req_bus.amount    <= op.amount;
        req_bus.valid     <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = src_gaps ? $urandom_range(1, 8) : 0;
        end
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Response ready: long hold-off on demand, otherwise the phase's pattern
  always @(negedge clk_i) begin
    if (stall_req && !stall_done) begin
      stall_left = LONG_STALL;
      stall_done = 1'b1;
    end
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      case (rsp_style)
        0: rsp_bus.ready <= 1'b1;
        1: rsp_bus.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (rsp_run_left > 0) begin
            rsp_run_left--;
            rsp_bus.ready <= 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            rsp_run_left = $urandom_range(1, 12);
            rsp_bus.ready <= 1'b0;
          end else begin
            rsp_bus.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Monitor: predict on each accepted request, check each accepted response
  always @(posedge clk_i) begin
    hole_op_t op;
    grant_t   want;
    req_taken = rst_ni && req_bus.valid && req_bus.ready;
    if (req_taken) begin
      op.func   = func_e'(req_bus.func);
      op.slot   = req_bus.hole_slot;
      op.amount = req_bus.amount;
      ops_accepted++;
      predict_grant(op);
    end
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected response", 32'(rsp_bus.chosen_hole), '0);
      end else begin
        want = grant_q.pop_front();
        grants_checked++;
        if (want.granted) grants_won++;
        if (rsp_bus.granted !== want.granted)
          report_mismatch("granted", 32'(rsp_bus.granted), 32'(want.granted));
        if (rsp_bus.chosen_hole !== want.hole)
          report_mismatch("chosen_hole", 32'(rsp_bus.chosen_hole), 32'(want.hole));
        if (rsp_bus.left_over !== want.left)
          report_mismatch("left_over", 32'(rsp_bus.left_over), 32'(want.left));
      end
    end
  end

  initial begin
    logic [MODE_W-1:0]  phase_mode  [PHASES];
    logic [COUNT_W-1:0] phase_count [PHASES];

    phase_mode  = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNUSED, FIT_BEST,
                    FIT_WORST, FIT_FIRST, FIT_BEST, FIT_WORST, FIT_FIRST};
    phase_count = '{5'd16, 5'd16, 5'd16, 5'd8, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd16};

    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.func      = FUNC_LOAD;
    req_bus.hole_slot = '0;
    req_bus.amount    = '0;
    rsp_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.reg_idx   = CFG_FIT_MODE;
    cfg_bus.wdata     = '0;
    shadow_mode       = FIT_FIRST;
    shadow_count      = '0;
    foreach (hole_size[i]) hole_size[i] = '0;
    src_gaps          = 1'b1;
    rsp_style         = 2;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Count zero: nothing examined, so no grant at any size
    queue_op(FUNC_REQUEST, 4'hf, 16'h0000);
    queue_op(FUNC_REQUEST, 4'h0, 16'hffff);
    // Fill the whole table before any request examines it; sizes repeat for ties
    queue_op(FUNC_LOAD, 4'h0, 16'h0000);
    queue_op(FUNC_LOAD, 4'h1, 16'hffff);
    for (int s = 2; s < NUM_HOLES; s++)
      queue_op(FUNC_LOAD, SLOT_W'(s), AMOUNT_W'((s % 4 + 1) * 16'h0400));
    wait_drained();

    write_reg(CFG_HOLE_COUNT, 5'd16);
    queue_op(FUNC_REQUEST, 4'h0, 16'h0000);   // zero request takes the first hole as is
    queue_op(FUNC_REQUEST, 4'h0, 16'hffff);   // only the full-size hole fits
    wait_drained();
    write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_BEST));
    queue_op(FUNC_REQUEST, 4'h5, 16'h0500);
    wait_drained();
    write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_WORST));
    queue_op(FUNC_REQUEST, 4'ha, 16'h0001);
    wait_drained();
    write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_UNUSED));   // falls back to first fit
    queue_op(FUNC_REQUEST, 4'h3, 16'h0001);
    wait_drained();
    write_reg(CFG_HOLE_COUNT, 5'd31);         // clamps to the table depth
    queue_op(FUNC_REQUEST, 4'hc, 16'h0001);
    wait_drained();
    write_reg(CFG_HOLE_COUNT, 5'd1);          // only the empty hole is visible
    queue_op(FUNC_REQUEST, 4'h7, 16'h0001);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        phase_mode[p]  = MODE_W'($urandom_range(0, 3));
        phase_count[p] = COUNT_W'($urandom_range(0, 31));
      end
      write_reg(CFG_FIT_MODE, CFG_DATA_W'(phase_mode[p]));
      write_reg(CFG_HOLE_COUNT, phase_count[p]);
      src_gaps  = (p % 3 != 0);
      rsp_style = (p + 1) % 3;
      if (p == 6) stall_req = 1'b1;   // back up the block while requests keep coming
      for (int n = 0; n < PHASE_OPS; n++) begin
        pending_ops.push_back(random_op());
        // Stop queueing until every request so far is taken and every grant has come back
        if (p == 4 && n == PHASE_OPS / 2) wait_drained();
      end
      wait_drained();
    end

    $display("tb: %0d requests accepted over %0d register settings", ops_accepted, PHASES + 7);
    $display("tb: %0d allocations checked, %0d granted", grants_checked, grants_won);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
